// ===== hdl/urs_pkg.sv =====
// Shared types, register map and arithmetic helpers of the ultrasonic ranging scanner.
`default_nettype none

package urs_pkg;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam int DIST_LANES = 4;

    // floor(us * 343 / 2000) == (us * MM_MULT) >> MM_SHIFT for us < 2**19
    localparam int          MM_US_BITS = 19;
    localparam int          MM_SHIFT   = 31;
    localparam logic [28:0] MM_MULT    = 29'd368293446;

    // floor(x / 10) == (x * DIV10_MULT) >> DIV10_SHIFT for x < 2**22
    localparam int          DIV10_SHIFT = 23;
    localparam logic [19:0] DIV10_MULT  = 20'd838861;

    localparam logic [15:0] FILT_RESET = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_EDGE   = 2'd1,
        OP_INJECT = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        REG_TIMER_RELOAD  = 3'd0,
        REG_SCAN_INTERVAL = 3'd1,
        REG_MIN_VALID     = 3'd2,
        REG_MAX_VALID     = 3'd3,
        REG_NO_ECHO       = 3'd4,
        REG_OBSTACLE      = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [15:0] timer_reload;
        logic [9:0]  scan_interval_ms;
        logic [15:0] min_valid_mm;
        logic [15:0] max_valid_mm;
        logic [15:0] no_echo_code;
        logic [15:0] obstacle_limit_mm;
    } t_cfg;

    typedef struct packed {
        t_op         op;
        logic [31:0] now_ms;
        logic [1:0]  sensor;
        logic [15:0] capture_count;
        logic [15:0] echo_us;
    } t_item;

    typedef struct packed {
        logic                        fire;
        logic [1:0]                  fire_sensor;
        logic                        waiting;
        logic [DIST_LANES-1:0][15:0] dist_mm;
        logic [DIST_LANES-1:0]       obstacle_mask;
    } t_result;

    // Echo time already scaled to millimetres; no_echo marks zero or overlong echoes.
    typedef struct packed {
        logic        no_echo;
        logic [16:0] mm;
    } t_conv;

    function automatic t_conv mm_convert(input logic [31:0] us);
        t_conv       c;
        logic [47:0] p;
        p         = 48'(us[MM_US_BITS-1:0]) * 48'(MM_MULT);
        c.mm      = p[47:MM_SHIFT];
        c.no_echo = (us == 32'd0) || (|us[31:MM_US_BITS]);
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/urs_cfg_regs.sv =====
// APB-style configuration register file of the ranging scanner.
`default_nettype none

module urs_cfg_regs
    import urs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    output t_cfg                       o_cfg
);

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[CFG_ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_idx)
                REG_TIMER_RELOAD:  n_cfg.timer_reload      = pwdata[15:0];
                REG_SCAN_INTERVAL: n_cfg.scan_interval_ms  = pwdata[9:0];
                REG_MIN_VALID:     n_cfg.min_valid_mm      = pwdata[15:0];
                REG_MAX_VALID:     n_cfg.max_valid_mm      = pwdata[15:0];
                REG_NO_ECHO:       n_cfg.no_echo_code      = pwdata[15:0];
                REG_OBSTACLE:      n_cfg.obstacle_limit_mm = pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_TIMER_RELOAD:  prdata = 32'(r_cfg.timer_reload);
            REG_SCAN_INTERVAL: prdata = 32'(r_cfg.scan_interval_ms);
            REG_MIN_VALID:     prdata = 32'(r_cfg.min_valid_mm);
            REG_MAX_VALID:     prdata = 32'(r_cfg.max_valid_mm);
            REG_NO_ECHO:       prdata = 32'(r_cfg.no_echo_code);
            REG_OBSTACLE:      prdata = 32'(r_cfg.obstacle_limit_mm);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timer_reload      <= 16'd65535;
            r_cfg.scan_interval_ms  <= 10'd25;
            r_cfg.min_valid_mm      <= 16'd20;
            r_cfg.max_valid_mm      <= 16'd4000;
            r_cfg.no_echo_code      <= 16'd65535;
            r_cfg.obstacle_limit_mm <= 16'd300;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== hdl/urs_core.sv =====
// Scan state and combinational transaction update of the ranging scanner.
`default_nettype none

module urs_core
    import urs_pkg::*;
#(
    parameter int SENSOR_COUNT = 4,
    parameter int COUNT_BITS   = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire logic  i_item_valid,
    input  wire t_item i_item,
    output t_result    o_result
);

    localparam int IDX_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SENSOR_COUNT - 1);

    logic [IDX_W-1:0]      r_active_index, n_active_index;
    logic [31:0]           r_last_fire_ms, n_last_fire_ms;
    logic                  r_wait_flag,    n_wait_flag;
    logic [COUNT_BITS-1:0] r_start_count [SENSOR_COUNT];
    logic [COUNT_BITS-1:0] n_start_count [SENSOR_COUNT];
    t_conv                 r_echo [SENSOR_COUNT];
    t_conv                 n_echo [SENSOR_COUNT];
    logic [SENSOR_COUNT-1:0] r_capturing, n_capturing;
    logic [SENSOR_COUNT-1:0] r_fresh,     n_fresh;
    logic [15:0]           r_filtered [SENSOR_COUNT];
    logic [15:0]           n_filtered [SENSOR_COUNT];

    logic [IDX_W-1:0]      w_sel;
    logic                  w_sel_ok;
    logic [IDX_W-1:0]      w_next_idx;
    logic [COUNT_BITS-1:0] w_cap;
    logic [COUNT_BITS-1:0] w_start;
    logic [COUNT_BITS-1:0] w_dur;
    logic [31:0]           w_us;
    t_conv                 w_conv;
    logic [31:0]           w_elapsed;
    logic                  w_first;
    logic                  w_due;
    logic                  w_timeout;
    t_conv                 w_act_echo;
    logic [15:0]           w_act_filt;
    logic [15:0]           w_raw;
    logic [19:0]           w_blend_sum;
    logic [39:0]           w_blend_prod;
    logic [15:0]           w_blend;
    logic [15:0]           w_settled;
    logic                  w_fire;

    // Echo edge and injection decode
    assign w_sel    = IDX_W'(i_item.sensor);
    assign w_sel_ok = int'(i_item.sensor) < SENSOR_COUNT;
    assign w_cap    = COUNT_BITS'(i_item.capture_count);
    assign w_start  = r_start_count[w_sel];
    assign w_dur    = (w_cap >= w_start) ? (w_cap - w_start)
                    : (COUNT_BITS'(i_cfg.timer_reload) - w_start + w_cap);
    assign w_us     = (i_item.op == OP_EDGE) ? 32'(w_dur) : 32'(i_item.echo_us);
    assign w_conv   = mm_convert(w_us);

    // Tick timing
    assign w_next_idx = (r_active_index == LAST_IDX) ? '0 : r_active_index + 1'b1;
    assign w_elapsed  = i_item.now_ms - r_last_fire_ms;
    assign w_first    = (r_last_fire_ms == 32'd0);
    assign w_due      = w_elapsed >= 32'(i_cfg.scan_interval_ms);
    assign w_timeout  = w_elapsed >= 32'({i_cfg.scan_interval_ms, 1'b0});

    // Settle the active sensor: window check, then 7:3 blend
    assign w_act_echo   = r_echo[r_active_index];
    assign w_act_filt   = r_filtered[r_active_index];
    assign w_raw        = (w_act_echo.no_echo
                          || (w_act_echo.mm < 17'(i_cfg.min_valid_mm))
                          || (w_act_echo.mm > 17'(i_cfg.max_valid_mm)))
                        ? i_cfg.no_echo_code : w_act_echo.mm[15:0];
    assign w_blend_sum  = 20'(w_raw) * 20'd7 + 20'(w_act_filt) * 20'd3;
    assign w_blend_prod = 40'(w_blend_sum) * 40'(DIV10_MULT);
    assign w_blend      = w_blend_prod[DIV10_SHIFT+15:DIV10_SHIFT];

    always_comb begin
        if (r_fresh[r_active_index]) begin
            if (w_act_filt == i_cfg.no_echo_code) begin
                w_settled = w_raw;
            end else if (w_raw != i_cfg.no_echo_code) begin
                w_settled = w_blend;
            end else begin
                w_settled = i_cfg.no_echo_code;
            end
        end else if (w_timeout) begin
            w_settled = i_cfg.no_echo_code;
        end else begin
            w_settled = w_act_filt;
        end
    end

    always_comb begin
        n_active_index = r_active_index;
        n_last_fire_ms = r_last_fire_ms;
        n_wait_flag    = r_wait_flag;
        n_start_count  = r_start_count;
        n_echo         = r_echo;
        n_capturing    = r_capturing;
        n_fresh        = r_fresh;
        n_filtered     = r_filtered;
        w_fire         = 1'b0;
        if (i_item_valid) begin
            case (i_item.op)
                OP_TICK: begin
                    if (w_first) begin
                        n_last_fire_ms              = i_item.now_ms;
                        n_capturing[r_active_index] = 1'b0;
                        n_fresh[r_active_index]     = 1'b0;
                        n_wait_flag                 = 1'b1;
                        w_fire                      = 1'b1;
                    end else if (w_due) begin
                        n_filtered[r_active_index] = w_settled;
                        n_fresh[r_active_index]    = 1'b0;
                        n_active_index             = w_next_idx;
                        n_last_fire_ms             = i_item.now_ms;
                        n_capturing[w_next_idx]    = 1'b0;
                        n_fresh[w_next_idx]        = 1'b0;
                        w_fire                     = 1'b1;
                    end
                end
                OP_EDGE: begin
                    if (w_sel_ok) begin
                        if (!r_capturing[w_sel]) begin
                            n_start_count[w_sel] = w_cap;
                            n_capturing[w_sel]   = 1'b1;
                        end else begin
                            n_echo[w_sel]      = w_conv;
                            n_capturing[w_sel] = 1'b0;
                            n_fresh[w_sel]     = 1'b1;
                        end
                    end
                end
                OP_INJECT: begin
                    if (w_sel_ok) begin
                        n_echo[w_sel]  = w_conv;
                        n_fresh[w_sel] = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_index <= '0;
            r_last_fire_ms <= '0;
            r_wait_flag    <= 1'b0;
            r_capturing    <= '0;
            r_fresh        <= '0;
            for (int i = 0; i < SENSOR_COUNT; i++) begin
                r_filtered[i] <= FILT_RESET;
            end
        end else begin
            r_active_index <= n_active_index;
            r_last_fire_ms <= n_last_fire_ms;
            r_wait_flag    <= n_wait_flag;
            r_capturing    <= n_capturing;
            r_fresh        <= n_fresh;
            r_filtered     <= n_filtered;
        end
    end

    // Echo payload is only read behind capturing or fresh
    always_ff @(posedge i_clk) begin
        r_start_count <= n_start_count;
        r_echo        <= n_echo;
    end

    assign o_result.fire        = w_fire;
    assign o_result.fire_sensor = w_fire ? 2'(n_active_index) : 2'd0;
    assign o_result.waiting     = n_wait_flag;

    for (genvar g = 0; g < DIST_LANES; g++) begin : g_lane
        if (g < SENSOR_COUNT) begin : g_used
            assign o_result.dist_mm[g]       = n_filtered[g];
            assign o_result.obstacle_mask[g] = (n_filtered[g] != 16'd0)
                                             && (n_filtered[g] < i_cfg.obstacle_limit_mm);
        end else begin : g_unused
            assign o_result.dist_mm[g]       = i_cfg.no_echo_code;
            assign o_result.obstacle_mask[g] = 1'b0;
        end
    end

`ifndef ASSERT_OFF
    a_fire_only_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item_valid && o_result.fire) |-> (i_item.op == OP_TICK))
        else $error("trigger issued by a non-tick transaction");

    a_fire_sets_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item_valid && o_result.fire) |=> r_wait_flag)
        else $error("wait flag clear after a trigger");

    a_active_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active_index <= LAST_IDX)
        else $error("active sensor index beyond sensor count");
`endif

endmodule

`default_nettype wire

// ===== hdl/urs_out_buf.sv =====
// Two-entry result buffer: output register plus skid register.
`default_nettype none

module urs_out_buf
    import urs_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_data,
    input  wire logic    i_ready,
    output logic         o_valid,
    output t_result      o_data,
    output logic         o_full
);

    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;
    logic    w_pop;

    assign w_pop   = r_out_valid && i_ready;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;
    assign o_full  = r_out_valid && r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (i_push && w_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_push) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= r_out_valid;
            end else if (w_pop) begin
                r_out_valid  <= r_skid_valid;
                r_skid_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && w_pop) begin
            if (r_skid_valid) begin
                r_out  <= r_skid;
                r_skid <= i_data;
            end else begin
                r_out <= i_data;
            end
        end else if (i_push) begin
            if (r_out_valid) begin
                r_skid <= i_data;
            end else begin
                r_out <= i_data;
            end
        end else if (w_pop) begin
            r_out <= r_skid;
        end
    end

`ifndef ASSERT_OFF
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without an output entry");
`endif

endmodule

`default_nettype wire

// ===== hdl/ultrasonic_ranging_scanner.sv =====
// Top level of the round-robin ultrasonic echo ranging scanner.
//
// Input channel (i_in_valid / o_in_ready) carries one transaction per item:
// a millisecond tick, an echo capture edge or an injected echo duration.
// Output channel (o_out_valid / i_out_ready) returns exactly one result per
// item: trigger flag and sensor, waiting flag, four filtered distances and
// the obstacle mask, all as they stand after that item's update.
// Path: an accepted item is held in the input register until the result
// buffer is not full; then it is applied to the scan state and its result is
// loaded into the result buffer in the same cycle.
// Throughput: one item per cycle while the result buffer is not full; the
// whole update (echo scaling multiply, window check, 7:3 blend with a
// reciprocal divide) sits between the input register and the result register.
// Stall: the result buffer holds two results; with both occupied and an item
// waiting in the input register, o_in_ready drops until the receiver takes
// a result. o_in_ready is registered state only, never a path from i_out_ready.
// Reset (i_rst_n low, synchronous) empties both channels, returns scan state
// to sensor 0 with no trigger seen, all distances to 65535, and loads the
// register defaults. Registers are written through the APB-style port.
`default_nettype none

module ultrasonic_ranging_scanner
    import urs_pkg::*;
#(
    parameter int SENSOR_COUNT = 4,
    parameter int COUNT_BITS   = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    // input channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [1:0]            i_op,
    input  wire logic [31:0]           i_now_ms,
    input  wire logic [1:0]            i_sensor,
    input  wire logic [15:0]           i_capture_count,
    input  wire logic [15:0]           i_echo_us,
    // output channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic                       o_fire,
    output logic      [1:0]            o_fire_sensor,
    output logic                       o_waiting,
    output logic      [15:0]           o_dist_a,
    output logic      [15:0]           o_dist_b,
    output logic      [15:0]           o_dist_c,
    output logic      [15:0]           o_dist_d,
    output logic      [3:0]            o_obstacle_mask
);

    t_cfg    w_cfg;
    t_item   r_in;
    logic    r_in_valid;
    logic    w_accept;
    logic    w_advance;
    logic    w_buf_full;
    t_result w_result;
    t_result w_out;

    urs_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Take a new transaction whenever the input register is free or moving on
    assign o_in_ready = !r_in_valid || !w_buf_full;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_advance  = r_in_valid && !w_buf_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // Hold the item payload until it moves into the core
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in.op            <= t_op'(i_op);
            r_in.now_ms        <= i_now_ms;
            r_in.sensor        <= i_sensor;
            r_in.capture_count <= i_capture_count;
            r_in.echo_us       <= i_echo_us;
        end
    end

    urs_core #(
        .SENSOR_COUNT (SENSOR_COUNT),
        .COUNT_BITS   (COUNT_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_item_valid (w_advance),
        .i_item       (r_in),
        .o_result     (w_result)
    );

    urs_out_buf u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_advance),
        .i_data  (w_result),
        .i_ready (i_out_ready),
        .o_valid (o_out_valid),
        .o_data  (w_out),
        .o_full  (w_buf_full)
    );

    assign o_fire          = w_out.fire;
    assign o_fire_sensor   = w_out.fire_sensor;
    assign o_waiting       = w_out.waiting;
    assign o_dist_a        = w_out.dist_mm[0];
    assign o_dist_b        = w_out.dist_mm[1];
    assign o_dist_c        = w_out.dist_mm[2];
    assign o_dist_d        = w_out.dist_mm[3];
    assign o_obstacle_mask = w_out.obstacle_mask;

endmodule

`default_nettype wire
